// ===== hw/rtl/two_button_click_hold_detector_core_defines.svh =====
// Assertion macros shared by the detector RTL.
`ifndef TWO_BUTTON_CLICK_HOLD_DETECTOR_CORE_DEFINES_SVH
`define TWO_BUTTON_CLICK_HOLD_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TBCHD_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TBCHD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tbchd_pkg.sv =====
`timescale 1ns / 1ps

package tbchd_pkg;

	localparam int TIME_BITS = 32;
	localparam int NOW_BITS  = 32;
	localparam int CFG_BITS  = 16;
	localparam int IDX_BITS  = 3;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [CFG_BITS-1:0]  thr_t;

	typedef enum logic [IDX_BITS-1:0] {
		REG_DEBOUNCE     = 3'd0,
		REG_DOUBLE_WIN   = 3'd1,
		REG_CLICK_MAX    = 3'd2,
		REG_HOLD_GUARD   = 3'd3,
		REG_RESTART_HOLD = 3'd4,
		REG_FACTORY_HOLD = 3'd5
	} cfg_idx_t;

	localparam thr_t RST_DEBOUNCE     = 16'd50;
	localparam thr_t RST_DOUBLE_WIN   = 16'd1500;
	localparam thr_t RST_CLICK_MAX    = 16'd200;
	localparam thr_t RST_HOLD_GUARD   = 16'd300;
	localparam thr_t RST_RESTART_HOLD = 16'd3000;
	localparam thr_t RST_FACTORY_HOLD = 16'd5000;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_SINGLE = 2'd1;
	localparam logic [1:0] EV_DOUBLE = 2'd2;

	localparam logic [1:0] IND_OFF     = 2'd0;
	localparam logic [1:0] IND_RESTART = 2'd1;
	localparam logic [1:0] IND_FACTORY = 2'd2;

	localparam logic [1:0] CNT_IDLE  = 2'd0;
	localparam logic [1:0] CNT_ONE   = 2'd1;
	localparam logic [1:0] CNT_TWO   = 2'd2;

	typedef struct packed {
		thr_t debounce;
		thr_t double_win;
		thr_t click_max;
		thr_t hold_guard;
		thr_t restart_hold;
		thr_t factory_hold;
	} cfg_t;

	function automatic time_t elapsed(time_t now, time_t since);
		return now - since;
	endfunction

	function automatic logic reached(time_t el, thr_t thr);
		return el >= time_t'(thr);
	endfunction

endpackage

// ===== hw/rtl/tbchd_cfg.sv =====
`timescale 1ns / 1ps

module tbchd_cfg import tbchd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  thr_t                cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce     <= RST_DEBOUNCE;
			cfg_q.double_win   <= RST_DOUBLE_WIN;
			cfg_q.click_max    <= RST_CLICK_MAX;
			cfg_q.hold_guard   <= RST_HOLD_GUARD;
			cfg_q.restart_hold <= RST_RESTART_HOLD;
			cfg_q.factory_hold <= RST_FACTORY_HOLD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_DEBOUNCE:     cfg_q.debounce     <= cfg_data;
				REG_DOUBLE_WIN:   cfg_q.double_win   <= cfg_data;
				REG_CLICK_MAX:    cfg_q.click_max    <= cfg_data;
				REG_HOLD_GUARD:   cfg_q.hold_guard   <= cfg_data;
				REG_RESTART_HOLD: cfg_q.restart_hold <= cfg_data;
				REG_FACTORY_HOLD: cfg_q.factory_hold <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/tbchd_alarm.sv =====
`timescale 1ns / 1ps

`include "two_button_click_hold_detector_core_defines.svh"

module tbchd_alarm import tbchd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       level,
	input  logic       restart,
	input  time_t      now,
	input  cfg_t       cfg,
	output logic [1:0] alarm_event
);

	logic       raw_q, deb_q, prev_q;
	logic [1:0] cnt_q;
	time_t      bounce_q, first_q;

	logic       raw_n, deb_n, rise;
	logic [1:0] cnt_mid, cnt_n;
	time_t      bounce_n, first_n;

	always_comb begin
		raw_n    = level;
		bounce_n = (level != raw_q) ? now : bounce_q;
		deb_n    = reached(elapsed(now, bounce_n), cfg.debounce) ? level : deb_q;
		rise     = !prev_q && deb_n;
		cnt_mid  = cnt_q;
		first_n  = first_q;
		if (rise && cnt_q == CNT_IDLE) begin
			cnt_mid = CNT_ONE;
			first_n = now;
		end else if (rise && cnt_q == CNT_ONE &&
				elapsed(now, first_q) <= time_t'(cfg.double_win)) begin
			cnt_mid = CNT_TWO;
		end
		alarm_event = EV_NONE;
		cnt_n       = cnt_mid;
		if (restart) begin
			alarm_event = EV_NONE;
		end else if (cnt_mid == CNT_TWO) begin
			alarm_event = EV_DOUBLE;
			cnt_n       = CNT_IDLE;
		end else if (cnt_mid == CNT_ONE &&
				elapsed(now, first_n) > time_t'(cfg.double_win)) begin
			alarm_event = EV_SINGLE;
			cnt_n       = CNT_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= 1'b0;
			deb_q    <= 1'b0;
			prev_q   <= 1'b0;
			cnt_q    <= CNT_IDLE;
			bounce_q <= '0;
			first_q  <= '0;
		end else if (adv && !restart) begin
			raw_q    <= raw_n;
			deb_q    <= deb_n;
			prev_q   <= deb_n;
			cnt_q    <= cnt_n;
			bounce_q <= bounce_n;
			first_q  <= first_n;
		end
	end

	`TBCHD_ASSERT_NOW(a_cnt_settled, 1'b1, cnt_q == CNT_IDLE || cnt_q == CNT_ONE, "press count left at two")
	`TBCHD_ASSERT_NOW(a_frozen_quiet, adv && restart, alarm_event == EV_NONE, "alarm event while restart held")
	`TBCHD_ASSERT_NOW(a_prev_tracks, 1'b1, prev_q == deb_q, "edge history diverged from debounced level")

endmodule

// ===== hw/rtl/tbchd_hold.sv =====
`timescale 1ns / 1ps

`include "two_button_click_hold_detector_core_defines.svh"

module tbchd_hold import tbchd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       alarm,
	input  logic       restart,
	input  time_t      now,
	input  cfg_t       cfg,
	output logic       restart_click,
	output logic [1:0] led_mode,
	output logic       restart_request,
	output logic       factory_reset_request
);

	logic       short_q, combo_armed_q, combo_fired_q, hold_armed_q, hold_fired_q;
	logic [1:0] led_q;
	time_t      short_start_q, combo_start_q, hold_start_q;

	logic       short_n, combo_armed_n, combo_fired_n, hold_armed_n, hold_fired_n;
	logic [1:0] led_mid, led_n;
	time_t      short_start_n, combo_start_n, hold_start_n;
	time_t      el_combo, el_hold;

	always_comb begin
		short_n       = short_q;
		short_start_n = short_start_q;
		restart_click = 1'b0;
		if (!alarm) begin
			if (restart && !short_q) begin
				short_start_n = now;
				short_n       = 1'b1;
			end
			if (!restart && short_q) begin
				short_n       = 1'b0;
				restart_click = elapsed(now, short_start_q) < time_t'(cfg.click_max);
			end
		end else begin
			short_n = 1'b0;
		end

		combo_armed_n         = combo_armed_q;
		combo_fired_n         = combo_fired_q;
		combo_start_n         = combo_start_q;
		led_mid               = led_q;
		factory_reset_request = 1'b0;
		if (alarm && restart) begin
			if (!combo_armed_q) begin
				combo_armed_n = 1'b1;
				combo_start_n = now;
			end
		end
		el_combo = elapsed(now, combo_start_n);
		if (alarm && restart) begin
			if (reached(el_combo, cfg.hold_guard))
				led_mid = IND_FACTORY;
			if (!combo_fired_q && reached(el_combo, cfg.factory_hold)) begin
				combo_fired_n         = 1'b1;
				factory_reset_request = 1'b1;
			end
		end else begin
			combo_armed_n = 1'b0;
			combo_fired_n = 1'b0;
			if (led_q == IND_FACTORY)
				led_mid = IND_OFF;
		end

		hold_armed_n    = hold_armed_q;
		hold_fired_n    = hold_fired_q;
		hold_start_n    = hold_start_q;
		led_n           = led_mid;
		restart_request = 1'b0;
		if (restart && !alarm && !hold_armed_q) begin
			hold_armed_n = 1'b1;
			hold_start_n = now;
		end
		el_hold = elapsed(now, hold_start_n);
		if (restart && !alarm) begin
			if (reached(el_hold, cfg.hold_guard))
				led_n = IND_RESTART;
			if (!hold_fired_q && reached(el_hold, cfg.restart_hold)) begin
				hold_fired_n    = 1'b1;
				restart_request = 1'b1;
			end
		end else begin
			hold_armed_n = 1'b0;
			hold_fired_n = 1'b0;
			if (led_mid == IND_RESTART)
				led_n = IND_OFF;
		end
		led_mode = led_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q       <= 1'b0;
			short_start_q <= '0;
			combo_armed_q <= 1'b0;
			combo_fired_q <= 1'b0;
			combo_start_q <= '0;
			hold_armed_q  <= 1'b0;
			hold_fired_q  <= 1'b0;
			hold_start_q  <= '0;
			led_q         <= IND_OFF;
		end else if (adv) begin
			short_q       <= short_n;
			short_start_q <= short_start_n;
			combo_armed_q <= combo_armed_n;
			combo_fired_q <= combo_fired_n;
			combo_start_q <= combo_start_n;
			hold_armed_q  <= hold_armed_n;
			hold_fired_q  <= hold_fired_n;
			hold_start_q  <= hold_start_n;
			led_q         <= led_n;
		end
	end

	`TBCHD_ASSERT_NOW(a_arm_exclusive, 1'b1, !(combo_armed_q && hold_armed_q), "combo and restart hold armed together")
	`TBCHD_ASSERT_NOW(a_click_alarm_up, adv && restart_click, !alarm && !restart, "restart click with a button down")
	`TBCHD_ASSERT_NOW(a_led_off_released, adv && !restart, led_mode == IND_OFF, "hold indication without restart held")

endmodule

// ===== hw/rtl/two_button_click_hold_detector_core.sv =====
// A sample beat accepted into the input register yields its result beat from the result register.
// Throughput: one sample per cycle; the input register and result register both
// advance whenever the result register is empty or being drained.
// Reset: arst_n clears all detector state, the pipeline valid bits and loads the
// default thresholds into the configuration registers.
`timescale 1ns / 1ps

`include "two_button_click_hold_detector_core_defines.svh"

module two_button_click_hold_detector_core import tbchd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                alarm_pressed,
	input  logic                restart_pressed,
	input  logic [NOW_BITS-1:0] now_ms,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          alarm_event,
	output logic                restart_click,
	output logic [1:0]          led_mode,
	output logic                restart_request,
	output logic                factory_reset_request
);

	cfg_t  cfg;

	logic                valid_s1;
	logic                alarm_s1, restart_s1;
	logic [NOW_BITS-1:0] now_s1;

	logic       valid_s2;
	logic [1:0] alarm_event_s2, led_mode_s2;
	logic       restart_click_s2, restart_request_s2, factory_reset_request_s2;

	logic       adv;
	time_t      now_t;
	logic [1:0] ev_c, led_c;
	logic       click_c, rreq_c, freq_c;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign now_t    = time_t'(now_s1);

	tbchd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tbchd_alarm u_alarm (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.level       (alarm_s1),
		.restart     (restart_s1),
		.now         (now_t),
		.cfg         (cfg),
		.alarm_event (ev_c)
	);

	tbchd_hold u_hold (
		.clk                   (clk),
		.arst_n                (arst_n),
		.adv                   (adv),
		.alarm                 (alarm_s1),
		.restart               (restart_s1),
		.now                   (now_t),
		.cfg                   (cfg),
		.restart_click         (click_c),
		.led_mode              (led_c),
		.restart_request       (rreq_c),
		.factory_reset_request (freq_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			alarm_s1   <= alarm_pressed;
			restart_s1 <= restart_pressed;
			now_s1     <= now_ms;
		end
		if (adv) begin
			alarm_event_s2           <= ev_c;
			restart_click_s2         <= click_c;
			led_mode_s2              <= led_c;
			restart_request_s2       <= rreq_c;
			factory_reset_request_s2 <= freq_c;
		end
	end

	assign out_valid             = valid_s2;
	assign alarm_event           = alarm_event_s2;
	assign restart_click         = restart_click_s2;
	assign led_mode              = led_mode_s2;
	assign restart_request       = restart_request_s2;
	assign factory_reset_request = factory_reset_request_s2;

	`TBCHD_ASSERT_NOW(a_stall_has_item, !in_ready, valid_s1 && valid_s2, "input stalled with a free stage")
	`TBCHD_ASSERT_NOW(a_one_request, valid_s2, !(restart_request && factory_reset_request), "restart and factory requests together")
	`TBCHD_ASSERT_NEXT(a_adv_fills, adv, valid_s2, "advanced beat missing from result register")

endmodule

// ===== bench/tb_two_button_click_hold_detector_core.sv =====
`timescale 1ns / 1ps

module tb_two_button_click_hold_detector_core;
	import tbchd_pkg::*;

	localparam logic [IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [1:0] ev;
		logic       click;
		logic [1:0] led;
		logic       rreq;
		logic       freq;
	} detection_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [IDX_BITS-1:0] cfg_index = REG_DEBOUNCE;
	logic [CFG_BITS-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                alarm_pressed = 1'b0;
	logic                restart_pressed = 1'b0;
	logic [NOW_BITS-1:0] now_ms = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [1:0]          alarm_event;
	logic                restart_click;
	logic [1:0]          led_mode;
	logic                restart_request;
	logic                factory_reset_request;

	two_button_click_hold_detector_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.alarm_pressed(alarm_pressed),
		.restart_pressed(restart_pressed),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.alarm_event(alarm_event),
		.restart_click(restart_click),
		.led_mode(led_mode),
		.restart_request(restart_request),
		.factory_reset_request(factory_reset_request)
	);

	always #5 clk = ~clk;

	cfg_t       limits;
	logic       raw_seen, level_seen, level_prev;
	time_t      settle_t, window_t;
	logic [1:0] presses;
	logic       tap_live;
	time_t      tap_t;
	logic       both_live, both_done;
	time_t      both_t;
	logic       solo_live, solo_done;
	time_t      solo_t;
	logic [1:0] led_now;

	detection_t  expected_detections[$];
	int          errors = 0;
	int          sent = 0;
	int          stall_left = 0;
	bit          calm = 1'b0;
	time_t       stamp = '0;

	function automatic time_t span(time_t now, time_t since);
		time_t d;
		d = now - since;
		return d;
	endfunction

	function automatic cfg_t default_limits();
		cfg_t c;
		c.debounce     = RST_DEBOUNCE;
		c.double_win   = RST_DOUBLE_WIN;
		c.click_max    = RST_CLICK_MAX;
		c.hold_guard   = RST_HOLD_GUARD;
		c.restart_hold = RST_RESTART_HOLD;
		c.factory_hold = RST_FACTORY_HOLD;
		return c;
	endfunction

	function automatic cfg_t random_limits(int unsigned hi);
		cfg_t c;
		c.debounce     = thr_t'($urandom_range(hi));
		c.double_win   = thr_t'($urandom_range(hi));
		c.click_max    = thr_t'($urandom_range(hi));
		c.hold_guard   = thr_t'($urandom_range(hi));
		c.restart_hold = thr_t'($urandom_range(hi));
		c.factory_hold = thr_t'($urandom_range(hi));
		return c;
	endfunction

	function automatic time_t pick_step(thr_t thr);
		int unsigned roll;
		int unsigned t32;
		roll = $urandom_range(99);
		t32 = 32'(thr);
		if (roll < 3)
			return $urandom;
		if (roll < 18)
			return $urandom_range(2);
		if (roll < 50)
			return $urandom_range(t32 + 2, (t32 > 2) ? t32 - 2 : 0);
		if (roll < 85)
			return $urandom_range(t32);
		return $urandom_range(2 * t32 + 10);
	endfunction

	task automatic reset_model();
		limits = default_limits();
		raw_seen = 1'b0;
		level_seen = 1'b0;
		level_prev = 1'b0;
		settle_t = '0;
		window_t = '0;
		presses = CNT_IDLE;
		tap_live = 1'b0;
		tap_t = '0;
		both_live = 1'b0;
		both_done = 1'b0;
		both_t = '0;
		solo_live = 1'b0;
		solo_done = 1'b0;
		solo_t = '0;
		led_now = IND_OFF;
	endtask

	task automatic predict_detection(input logic a, input logic r, input time_t t);
		detection_t d;
		d = '0;
		d.ev = EV_NONE;
		if (!r) begin
			if (a != raw_seen) begin
				settle_t = t;
				raw_seen = a;
			end
			if (span(t, settle_t) >= limits.debounce)
				level_seen = a;
			if (!level_prev && level_seen) begin
				if (presses == CNT_IDLE) begin
					presses = CNT_ONE;
					window_t = t;
				end else if (presses == CNT_ONE && span(t, window_t) <= limits.double_win) begin
					presses = CNT_TWO;
				end
			end
			level_prev = level_seen;
			if (presses >= CNT_TWO) begin
				presses = CNT_IDLE;
				d.ev = EV_DOUBLE;
			end else if (presses == CNT_ONE && span(t, window_t) > limits.double_win) begin
				presses = CNT_IDLE;
				d.ev = EV_SINGLE;
			end
		end

		if (!a) begin
			if (r && !tap_live) begin
				tap_t = t;
				tap_live = 1'b1;
			end
			if (!r && tap_live) begin
				tap_live = 1'b0;
				if (span(t, tap_t) < limits.click_max)
					d.click = 1'b1;
			end
		end else begin
			tap_live = 1'b0;
		end

		if (a && r) begin
			if (!both_live) begin
				both_live = 1'b1;
				both_t = t;
				solo_live = 1'b0;
				solo_done = 1'b0;
			end
			if (span(t, both_t) >= limits.hold_guard)
				led_now = IND_FACTORY;
			if (!both_done && span(t, both_t) >= limits.factory_hold) begin
				both_done = 1'b1;
				d.freq = 1'b1;
			end
		end else begin
			both_live = 1'b0;
			both_done = 1'b0;
			if (led_now == IND_FACTORY)
				led_now = IND_OFF;
		end

		if (r && !a) begin
			if (!solo_live) begin
				solo_live = 1'b1;
				solo_t = t;
			end
			if (span(t, solo_t) >= limits.hold_guard)
				led_now = IND_RESTART;
			if (!solo_done && span(t, solo_t) >= limits.restart_hold) begin
				solo_done = 1'b1;
				d.rreq = 1'b1;
			end
		end else begin
			solo_live = 1'b0;
			solo_done = 1'b0;
			if (led_now == IND_RESTART)
				led_now = IND_OFF;
		end

		d.led = led_now;
		expected_detections.push_back(d);
	endtask

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE:     limits.debounce = cfg_data;
				REG_DOUBLE_WIN:   limits.double_win = cfg_data;
				REG_CLICK_MAX:    limits.click_max = cfg_data;
				REG_HOLD_GUARD:   limits.hold_guard = cfg_data;
				REG_RESTART_HOLD: limits.restart_hold = cfg_data;
				REG_FACTORY_HOLD: limits.factory_hold = cfg_data;
				default: ;
			endcase
		end
		if (arst_n && in_valid && in_ready)
			predict_detection(alarm_pressed, restart_pressed, now_ms);
	end

	always @(posedge clk) begin : check_results
		detection_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_detections.size() == 0) begin
				$error("result beat with no sample pending");
				errors++;
			end else begin
				want = expected_detections.pop_front();
				if (alarm_event !== want.ev) begin
					$error("alarm_event: expected %0d, got %0d", want.ev, alarm_event);
					errors++;
				end
				if (restart_click !== want.click) begin
					$error("restart_click: expected %0d, got %0d", want.click, restart_click);
					errors++;
				end
				if (led_mode !== want.led) begin
					$error("led_mode: expected %0d, got %0d", want.led, led_mode);
					errors++;
				end
				if (restart_request !== want.rreq) begin
					$error("restart_request: expected %0d, got %0d", want.rreq,
						restart_request);
					errors++;
				end
				if (factory_reset_request !== want.freq) begin
					$error("factory_reset_request: expected %0d, got %0d", want.freq,
						factory_reset_request);
					errors++;
				end
			end
		end
	end

	// hold off the result side while stall_left runs down, else keep it ready when calm or idle it at random
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 15);
		end
	end

	task automatic send_sample(input logic a, input logic r, input time_t t);
		if (!calm) begin
			while ($urandom_range(99) < 15) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		alarm_pressed <= a;
		restart_pressed <= r;
		now_ms <= t;
		stamp = t;
		sent++;
		@(posedge clk iff in_ready);
	endtask

	task automatic hold_level(input logic a, input logic r, input thr_t thr, input int unsigned n);
		repeat (n)
			send_sample(a, r, stamp + pick_step(thr));
	endtask

	// drop valid and wait until every sample beat has come back
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_detections.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input thr_t val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk iff cfg_ready);
	endtask

	task automatic load_config(input cfg_t c, input bit spares);
		write_reg(REG_DEBOUNCE, c.debounce);
		write_reg(REG_DOUBLE_WIN, c.double_win);
		write_reg(REG_CLICK_MAX, c.click_max);
		write_reg(REG_HOLD_GUARD, c.hold_guard);
		write_reg(REG_RESTART_HOLD, c.restart_hold);
		write_reg(REG_FACTORY_HOLD, c.factory_hold);
		if (spares) begin
			write_reg(REG_SPARE_LO, thr_t'($urandom_range(65535)));
			write_reg(REG_SPARE_HI, thr_t'($urandom_range(65535)));
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic play_gesture();
		int unsigned n;
		thr_t thr;
		n = $urandom_range(1, 4);
		case ($urandom_range(9))
			0, 1: begin
				hold_level(1'b1, 1'b0, limits.debounce, n);
				hold_level(1'b0, 1'b0, limits.debounce, $urandom_range(1, 4));
				hold_level(1'b0, 1'b0, limits.double_win, $urandom_range(1, 2));
			end
			2, 3: begin
				hold_level(1'b1, 1'b0, limits.debounce, n);
				hold_level(1'b0, 1'b0, limits.debounce, $urandom_range(1, 3));
				hold_level(1'b1, 1'b0, limits.debounce, $urandom_range(1, 3));
				hold_level(1'b0, 1'b0, limits.debounce, $urandom_range(1, 3));
				hold_level(1'b0, 1'b0, limits.double_win, 1);
			end
			4: begin
				hold_level(1'b0, 1'b1, limits.click_max, $urandom_range(1, 2));
				hold_level(1'b0, 1'b0, limits.click_max, 1);
			end
			5: begin
				thr = $urandom_range(1) ? limits.hold_guard : limits.restart_hold;
				hold_level(1'b0, 1'b1, thr, $urandom_range(2, 6));
				hold_level(1'b0, 1'b0, limits.click_max, 1);
			end
			6: begin
				thr = $urandom_range(1) ? limits.hold_guard : limits.factory_hold;
				hold_level(1'b1, 1'b1, thr, $urandom_range(2, 6));
				case ($urandom_range(2))
					0: hold_level(1'b0, 1'b0, limits.click_max, 1);
					1: hold_level(1'b1, 1'b0, limits.click_max, 1);
					default: hold_level(1'b0, 1'b1, limits.click_max, 1);
				endcase
			end
			7: begin
				hold_level(1'b1, 1'b0, limits.debounce, 2);
				hold_level(1'b1, 1'b1, limits.hold_guard, $urandom_range(1, 4));
				hold_level(1'b0, 1'b1, limits.hold_guard, $urandom_range(1, 3));
				hold_level(1'b0, 1'b0, limits.click_max, 1);
			end
			8: begin
				repeat (n * 3)
					send_sample(1'($urandom_range(1)), $urandom_range(9) == 0,
						stamp + pick_step(limits.debounce >> 1));
			end
			default: begin
				repeat (n)
					send_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
						stamp + pick_step(thr_t'($urandom_range(65535))));
			end
		endcase
	endtask

	task automatic test_alarm_clicks();
		send_sample(1'b1, 1'b0, 32'd0);
		send_sample(1'b1, 1'b0, 32'd60);
		send_sample(1'b0, 1'b0, 32'd100);
		send_sample(1'b0, 1'b0, 32'd200);
		send_sample(1'b1, 1'b0, 32'd300);
		send_sample(1'b1, 1'b0, 32'd400);
		// a later release and re-press counts as a fresh first press
		send_sample(1'b1, 1'b0, 32'd3000);
		send_sample(1'b1, 1'b0, 32'd3100);
		send_sample(1'b0, 1'b0, 32'd3200);
		send_sample(1'b0, 1'b0, 32'd3300);
		send_sample(1'b1, 1'b0, 32'd3400);
		send_sample(1'b1, 1'b0, 32'd4700);
	endtask

	task automatic test_restart_and_combo();
		send_sample(1'b0, 1'b1, 32'd10000);
		send_sample(1'b0, 1'b0, 32'd10100);
		send_sample(1'b0, 1'b1, 32'd11000);
		send_sample(1'b1, 1'b1, 32'd11050);
		send_sample(1'b0, 1'b0, 32'd11100);
		send_sample(1'b0, 1'b1, 32'd12000);
		send_sample(1'b0, 1'b1, 32'd15000);
		send_sample(1'b0, 1'b0, 32'd15200);
		send_sample(1'b1, 1'b1, 32'd16000);
		send_sample(1'b1, 1'b1, 32'd21000);
		send_sample(1'b0, 1'b0, 32'd21100);
	endtask

	task automatic test_threshold_extremes();
		quiesce();
		load_config('0, 1'b0);
		send_sample(1'b1, 1'b0, 32'hFFFF_FFFF);
		send_sample(1'b0, 1'b1, 32'h0000_0000);
		send_sample(1'b1, 1'b1, 32'h0000_0001);
		send_sample(1'b0, 1'b0, 32'h0000_0002);
		quiesce();
		load_config('1, 1'b1);
		send_sample(1'b1, 1'b0, 32'hFFFF_FF00);
		send_sample(1'b1, 1'b0, 32'h0000_FEFF);
		send_sample(1'b0, 1'b0, 32'h0001_FEFE);
		send_sample(1'b0, 1'b0, 32'h0001_FEFF);
	endtask

	task automatic test_backpressure();
		stall_left = 300;
		calm = 1'b1;
		repeat (30)
			send_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
				stamp + $urandom_range(400));
		calm = 1'b0;
	endtask

	task automatic test_random_gestures(input cfg_t c, input int n, input bit quiet,
		input bit spares);
		int target;
		quiesce();
		load_config(c, spares);
		calm = quiet;
		target = sent + n;
		while (sent < target)
			play_gesture();
		calm = 1'b0;
	endtask

	initial begin
		reset_model();
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_alarm_clicks();
		test_restart_and_combo();
		test_threshold_extremes();
		test_backpressure();
		test_random_gestures(default_limits(), 250, 1'b1, 1'b0);
		test_random_gestures(random_limits(40), 300, 1'b0, 1'b0);
		test_random_gestures('0, 100, 1'b0, 1'b0);
		test_random_gestures('1, 150, 1'b0, 1'b0);
		test_random_gestures(random_limits(65535), 200, 1'b0, 1'b1);
		test_random_gestures(random_limits(3000), 200, 1'b0, 1'b0);

		quiesce();
		repeat (6)
			@(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
